FILE: hw/rtl/bsf_pkg.sv
// Shared types, constants and helpers for the blocked-word substring filter.
package bsf_pkg;

   localparam int ENTRIES    = 64;
   localparam int MAX_WORD   = 24;
   localparam int ENT_W      = $clog2(ENTRIES);
   localparam int POS_W      = $clog2(MAX_WORD);
   localparam int LEN_W      = $clog2(MAX_WORD + 1);
   localparam int BYTES_W    = $clog2(ENTRIES * MAX_WORD);
   localparam logic [7:0] APOSTROPHE = 8'h27;
   localparam logic [7:0] LAST_CTRL  = 8'd32;

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_WRITE = 2'd1,
      OP_SETLEN = 2'd2,
      OP_TEXT  = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      RSN_NONE  = 2'd0,
      RSN_ABUSE = 2'd1,
      RSN_NAME  = 2'd2,
      RSN_BYTE  = 2'd3
   } reason_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [5:0] entry;
      logic [4:0] position;
      logic [7:0] byte_value;
      logic [4:0] entry_length;
      logic       list_tag;
      logic       name_check;
      logic       has_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic       acceptable;
      logic [1:0] reason;
      logic [5:0] matched_entry;
      logic [7:0] bad_byte;
   } rsp_type;

   // Per-entry record held in the entry memory.
   typedef struct packed {
      logic [LEN_W-1:0]    len;
      logic                list;
      logic [MAX_WORD-1:0] partial;
      logic                hit;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Word byte address of one entry position.
   function automatic logic [BYTES_W-1:0] byte_addr(input logic [ENT_W-1:0] e,
                                                    input logic [POS_W-1:0] p);
      logic [BYTES_W+POS_W-1:0] a;
      a = BYTES_W'(e) * BYTES_W'(MAX_WORD) + BYTES_W'(p);
      return a[BYTES_W-1:0];
   endfunction

endpackage

FILE: hw/rtl/blocklist_substring_filter.sv
// Blocked-word filter: each text byte updates every valid entry of nonzero length, walked one entry at a time.
// Table writes (opcodes 0..2) and text items with neither a byte nor end of text are taken in ST_IDLE.
// A text byte walks all ENTRIES entries; for each, ST_LOAD reads the word bytes and ST_WALK updates the record.
// An end-of-text item then scans every entry record in ST_SCAN for the verdict, and ST_OUT presents it.
// Reset clears valid bits and text state at once; word bytes stay undefined until written.
// The result sits in an output register; the input is taken only in ST_IDLE, and ST_OUT waits while one is held.
module blocklist_substring_filter (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bsf_pkg::rsp_type rsp_data
);

   localparam int EW = bsf_pkg::ENT_W;
   localparam int MW = bsf_pkg::MAX_WORD;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_LOAD = 5'b00010,
      ST_WALK = 5'b00100,
      ST_SCAN = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   bsf_pkg::req_type cur_ff, cur_in;
   logic [EW:0] idx_ff, idx_in;       // entry being read
   logic [4:0]  pos_ff, pos_in;       // byte position being read
   logic [MW-1:0] word_ff, word_in;   // byte-equal vector for current entry
   logic [EW-1:0] rd_ent_ff;          // entry whose record is on the read port

   logic [bsf_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [bsf_pkg::ENTRIES-1:0] fresh_ff, fresh_in; // record cleared since last write
   logic text_ff, text_in;
   logic [8:0] bad_ff, bad_in;
   logic abuse_ff, abuse_in, name_ff, name_in;
   logic [EW-1:0] abuse_idx_ff, abuse_idx_in, name_idx_ff, name_idx_in;
   logic rsp_valid_ff, rsp_valid_in;
   bsf_pkg::rsp_type rsp_ff, rsp_in;

   // Word byte memory.
   logic                        bw_en;
   logic [bsf_pkg::BYTES_W-1:0] bw_addr, br_addr;
   logic [7:0]                  br_data;
   // Entry record memory.
   logic                        ew_en;
   logic [EW-1:0]               ew_addr, er_addr;
   bsf_pkg::entry_type          ew_data, er_data, er_rec;

   bsf_ram #(.WIDTH(8), .DEPTH(bsf_pkg::ENTRIES * MW)) u_bytes (
      .clock(clock), .wr_en(bw_en), .wr_addr(bw_addr), .wr_data(req_data.byte_value),
      .rd_addr(br_addr), .rd_data(br_data));

   bsf_ram #(.WIDTH(bsf_pkg::ENTRY_W), .DEPTH(bsf_pkg::ENTRIES)) u_entries (
      .clock(clock), .wr_en(ew_en), .wr_addr(ew_addr), .wr_data(ew_data),
      .rd_addr(er_addr), .rd_data(er_data));

   // Sequence per text byte and entry: read MW word bytes (one per cycle) and the
   // record, build the equality vector, then update the record. A byte's entry
   // walk: pos runs 0..MW, word byte read at pos, compared in the next cycle.
   logic [EW-1:0] ent;
   logic accept;
   logic [MW-1:0] nxt;
   logic [bsf_pkg::LEN_W-1:0] len_sat;

   assign ent = idx_ff[EW-1:0];
   assign accept = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;
   assign br_addr = bsf_pkg::byte_addr(ent, pos_ff[bsf_pkg::POS_W-1:0]);
   assign er_addr = ent;
   assign len_sat = (req_data.entry_length > 5'(MW)) ? bsf_pkg::LEN_W'(MW)
                                                     : bsf_pkg::LEN_W'(req_data.entry_length);

   // A record not rewritten since clear reads as zero progress.
   always_comb begin
      er_rec = er_data;
      if (fresh_ff[rd_ent_ff]) begin
         er_rec.partial = '0;
         er_rec.hit = 1'b0;
      end
   end

   always_comb begin
      nxt = '0;
      if (er_rec.len != '0) begin
         nxt[0] = word_ff[0];
      end
      for (int j = 1; j < MW; j++) begin
         if (j < int'(er_rec.len)) begin
            nxt[j] = word_ff[j] && er_rec.partial[j-1];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      word_in = word_ff;
      valid_in = valid_ff;
      fresh_in = fresh_ff;
      text_in = text_ff;
      bad_in = bad_ff;
      abuse_in = abuse_ff;
      name_in = name_ff;
      abuse_idx_in = abuse_idx_ff;
      name_idx_in = name_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in = rsp_ff;
      bw_en = 1'b0;
      bw_addr = bsf_pkg::byte_addr(req_data.entry, req_data.position[bsf_pkg::POS_W-1:0]);
      ew_en = 1'b0;
      ew_addr = req_data.entry;
      ew_data = '0;
      ew_data.len = len_sat;
      ew_data.list = req_data.list_tag;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cur_in = req_data;
               idx_in = '0;
               pos_in = '0;
               unique case (req_data.opcode)
                  bsf_pkg::OP_CLEAR: begin
                     valid_in = '0;
                     fresh_in = '1;
                     text_in = 1'b0;
                     bad_in = '0;
                  end
                  bsf_pkg::OP_WRITE: begin
                     bw_en = (req_data.position < 5'(MW));
                  end
                  bsf_pkg::OP_SETLEN: begin
                     ew_en = 1'b1;
                     valid_in[req_data.entry] = 1'b1;
                     fresh_in[req_data.entry] = 1'b0;
                  end
                  default: begin
                     if (req_data.has_byte) begin
                        text_in = 1'b1;
                        if (!bad_ff[8] && ((req_data.byte_value >= 8'd1 &&
                            req_data.byte_value <= bsf_pkg::LAST_CTRL) ||
                            req_data.byte_value == bsf_pkg::APOSTROPHE)) begin
                           bad_in = {1'b1, req_data.byte_value};
                        end
                        state_in = ST_LOAD;
                     end else if (req_data.end_of_text) begin
                        state_in = ST_SCAN;
                        abuse_in = 1'b0;
                        name_in = 1'b0;
                     end
                  end
               endcase
            end
         end
         ST_LOAD: begin
            // Word byte at pos_ff-1 arrives now.
            if (pos_ff != 5'd0) begin
               word_in[pos_ff - 5'd1] = (br_data == cur_ff.byte_value);
            end
            pos_in = pos_ff + 5'd1;
            if (pos_ff == 5'(MW)) begin
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            // er_rec has been read for this entry throughout the load.
            if (valid_ff[ent] && er_rec.len != '0) begin
               ew_en = 1'b1;
               ew_addr = ent;
               ew_data = er_rec;
               ew_data.partial = nxt;
               ew_data.hit = er_rec.hit || nxt[er_rec.len - 1'b1];
               fresh_in[ent] = 1'b0;
            end
            pos_in = '0;
            if (idx_ff == (EW+1)'(bsf_pkg::ENTRIES - 1)) begin
               idx_in = '0;
               if (cur_ff.end_of_text) begin
                  state_in = ST_SCAN;
                  abuse_in = 1'b0;
                  name_in = 1'b0;
               end else begin
                  state_in = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_SCAN: begin
            // Record for idx_ff-1 is on the read port.
            if (idx_ff != '0) begin
               if (valid_ff[EW'(idx_ff - 1'b1)] &&
                   (er_rec.hit || (er_rec.len == '0 && text_ff))) begin
                  if (!er_rec.list && !abuse_ff) begin
                     abuse_in = 1'b1;
                     abuse_idx_in = EW'(idx_ff - 1'b1);
                  end
                  if (er_rec.list && !name_ff) begin
                     name_in = 1'b1;
                     name_idx_in = EW'(idx_ff - 1'b1);
                  end
               end
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == (EW+1)'(bsf_pkg::ENTRIES)) begin
               state_in = ST_OUT;
               idx_in = '0;
            end
         end
         ST_OUT: begin
            // Wait here while the previous verdict still occupies the output register.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in = '0;
               if (abuse_ff) begin
                  rsp_in.reason = bsf_pkg::RSN_ABUSE;
                  rsp_in.matched_entry = 6'(abuse_idx_ff);
               end else if (cur_ff.name_check && name_ff) begin
                  rsp_in.reason = bsf_pkg::RSN_NAME;
                  rsp_in.matched_entry = 6'(name_idx_ff);
               end else if (cur_ff.name_check && bad_ff[8]) begin
                  rsp_in.reason = bsf_pkg::RSN_BYTE;
                  rsp_in.bad_byte = bad_ff[7:0];
               end else begin
                  rsp_in.reason = bsf_pkg::RSN_NONE;
               end
               rsp_in.acceptable = (rsp_in.reason == bsf_pkg::RSN_NONE);
               rsp_valid_in = 1'b1;
               // Clear text state: mark every record fresh.
               fresh_in = '1;
               text_in = 1'b0;
               bad_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= '0;
         fresh_ff <= '1;
         text_ff <= 1'b0;
         bad_ff <= '0;
         rsp_valid_ff <= 1'b0;
         abuse_ff <= 1'b0;
         name_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         fresh_ff <= fresh_in;
         text_ff <= text_in;
         bad_ff <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         abuse_ff <= abuse_in;
         name_ff <= name_in;
      end
      cur_ff <= cur_in;
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      word_ff <= word_in;
      rd_ent_ff <= er_addr;
      abuse_idx_ff <= abuse_idx_in;
      name_idx_ff <= name_idx_in;
      rsp_ff <= rsp_in;
   end

endmodule

FILE: hw/rtl/bsf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
